// ===== src/dfs_pkg.sv =====
// dfs_pkg: shared types and constants for the distance formation step block.
// Used by dfs_cell, dfs_mul and distance_formation_step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int ACC_W     = 128;
  localparam int MUL_AW    = 72;
  localparam int MUL_BW    = 34;
  localparam int MUL_CH    = 18;
  localparam int MUL_NCH   = MUL_AW / MUL_CH;
  localparam int LIMIT_Q16 = 20972;
  localparam int HALF_Q16  = 32768;

  typedef enum logic [1:0] {OP_ADD, OP_UPD, OP_STEP, OP_NOP} op_t;
  typedef enum logic [1:0] {ST_OK, ST_FULL, ST_MISS} status_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] d;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic pose_we;
    logic dist_we;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== src/dfs_cell.sv =====
// dfs_cell: one table slot holding an agent pose and desired distance.
// Rotates toward its neighbor on shift. Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfs_cell #(
  parameter int ID = 0,
  parameter int IW = 5
) (
  input  wire logic              clk,
  input  wire dfs_pkg::cell_ctl_t ctl,
  input  wire logic [IW-1:0]     wr_sel,
  input  wire dfs_pkg::entry_t   wr_ent,
  input  wire dfs_pkg::entry_t   nb_ent,
  output dfs_pkg::entry_t        ent
);
  import dfs_pkg::*;

  entry_t ent_r;
  logic   sel;

  assign sel = (wr_sel == IW'(ID));
  assign ent = ent_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent_r <= nb_ent;
    end else if (sel) begin
      if (ctl.pose_we) begin
        ent_r.x <= wr_ent.x;
        ent_r.y <= wr_ent.y;
        ent_r.z <= wr_ent.z;
      end
      if (ctl.dist_we) begin
        ent_r.d <= wr_ent.d;
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/dfs_mul.sv =====
// dfs_mul: sequential signed multiplier, 72 x 34 bits into 128 bits,
// one 18-bit digit of the wide operand per cycle. Depends on dfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfs_mul (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [dfs_pkg::MUL_AW-1:0] a,
  input  wire logic signed [dfs_pkg::MUL_BW-1:0] b,
  output logic                                   done,
  output logic signed [dfs_pkg::ACC_W-1:0]       prod
);
  import dfs_pkg::*;

  localparam int CNT_W = $clog2(MUL_NCH);

  logic                     busy_r;
  logic                     done_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [MUL_AW-1:0]        a_sh_r;
  logic signed [MUL_BW-1:0] b_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [MUL_CH:0]   dig;
  logic signed [MUL_CH+MUL_BW:0] pp;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_comb begin
    if (cnt_r == '0) begin
      dig = {a_sh_r[MUL_AW-1], a_sh_r[MUL_AW-1 -: MUL_CH]};
    end else begin
      dig = {1'b0, a_sh_r[MUL_AW-1 -: MUL_CH]};
    end
    pp      = dig * b_r;
    acc_nxt = (acc_r <<< MUL_CH) + ACC_W'(pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_sh_r <= a;
        b_r    <= b;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        a_sh_r <= a_sh_r << MUL_CH;
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_NCH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ===== src/distance_formation_step.sv =====
// distance_formation_step: top level, agent table as a rotating row of cells,
// one shared sequential multiplier. Depends on dfs_pkg, dfs_cell, dfs_mul.
//
// Add, update and the unused operation are carried out on transfer; their result
// strobes out_valid in the next cycle and start may be taken again at once.
// A step holds busy while the agent row rotates past the shared multiplier:
// it runs 7 multiplies per stored agent, then rotates the row back into
// order unless the table is full or empty, then runs 6 multiplies for the
// sphere term. Each result is shown for one cycle on out_valid and cannot
// be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module distance_formation_step #(
  parameter int SLOTS = dfs_pkg::SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic [3:0]         in_agent_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_desired_distance,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_target_x,
  output logic signed [31:0]      out_target_y,
  output logic signed [31:0]      out_target_z
);
  import dfs_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_ROT, S_FIN} state_t;
  typedef enum logic [2:0] {MS_XX, MS_YY, MS_ZZ, MS_DD, MS_PX, MS_PY, MS_PZ} mstep_t;

  function automatic logic signed [31:0] fin_axis(logic signed [31:0] p,
                                                  logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] q;
    logic signed [33:0]      t;
    lim = ACC_W'(LIMIT_Q16) << 32;
    c = s;
    if (s > lim) c = lim;
    if (s < -lim) c = -lim;
    q = c >>> 34;
    t = 34'(q) + 34'(p);
    if (t[33:31] != 3'b000 && t[33:31] != 3'b111) begin
      return t[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return t[31:0];
  endfunction

  state_t  st_r;
  mstep_t  m_r;
  logic    sph_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [ACC_W-1:0] t_r, sx_r, sy_r, sz_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic signed [31:0] tx_r, ty_r, tz_r;

  entry_t    ent [SLOTS];
  entry_t    head;
  entry_t    wr_ent;
  cell_ctl_t ctl;
  logic [CW-1:0] wr_sel;
  logic      take, room, hit;
  logic      agent_last;

  logic signed [32:0] ex_c, ey_c, ez_c, e_sel;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic mul_start, mul_done;
  logic signed [ACC_W-1:0] prod;

  assign head   = ent[0];
  assign take   = start && !busy;
  assign room   = count_r < CW'(SLOTS);
  assign hit    = 32'(in_agent_index) < 32'(count_r);
  assign wr_sel = (op_t'(in_operation) == OP_ADD) ? count_r : CW'(in_agent_index);
  assign wr_ent = '{x: in_pos_x, y: in_pos_y, z: in_pos_z, d: in_desired_distance};
  assign agent_last = (st_r == S_WAIT) && mul_done && (m_r == MS_PZ) && !sph_r;

  always_comb begin
    ctl.shift   = agent_last || (st_r == S_ROT);
    ctl.dist_we = (st_r == S_IDLE) && take && (op_t'(in_operation) == OP_ADD) && room;
    ctl.pose_we = ctl.dist_we ||
                  ((st_r == S_IDLE) && take && (op_t'(in_operation) == OP_UPD) && hit);
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dfs_cell #(.ID(i), .IW(CW)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_sel (wr_sel),
      .wr_ent (wr_ent),
      .nb_ent (ent[(i + 1) % SLOTS]),
      .ent    (ent[i])
    );
  end

  always_comb begin
    if (sph_r) begin
      ex_c = {px_r[31], px_r};
      ey_c = {py_r[31], py_r};
      ez_c = {pz_r[31], pz_r} - 33'(HALF_Q16);
    end else begin
      ex_c = {px_r[31], px_r} - {head.x[31], head.x};
      ey_c = {py_r[31], py_r} - {head.y[31], head.y};
      ez_c = {pz_r[31], pz_r} - {head.z[31], head.z};
    end
    unique case (m_r)
      MS_XX, MS_PX: e_sel = ex_c;
      MS_YY, MS_PY: e_sel = ey_c;
      default:      e_sel = ez_c;
    endcase
    unique case (m_r)
      MS_XX, MS_YY, MS_ZZ: begin
        mul_a = MUL_AW'(e_sel);
        mul_b = MUL_BW'(e_sel);
      end
      MS_DD: begin
        mul_a = MUL_AW'(head.d);
        mul_b = MUL_BW'(head.d);
      end
      default: begin
        mul_a = t_r[MUL_AW-1:0];
        mul_b = sph_r ? {e_sel, 1'b0} : MUL_BW'(e_sel);
      end
    endcase
  end

  assign mul_start = (st_r == S_ISSUE) && !(sph_r && m_r == MS_DD);

  dfs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      m_r         <= MS_XX;
      sph_r       <= 1'b0;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (take) begin
            tx_r <= '0;
            ty_r <= '0;
            tz_r <= '0;
            out_status_r <= ST_OK;
            unique case (op_t'(in_operation))
              OP_ADD: begin
                out_valid_r <= 1'b1;
                if (room) count_r <= count_r + CW'(1);
                else out_status_r <= ST_FULL;
              end
              OP_UPD: begin
                out_valid_r <= 1'b1;
                if (!hit) out_status_r <= ST_MISS;
              end
              OP_STEP: begin
                px_r  <= in_pos_x;
                py_r  <= in_pos_y;
                pz_r  <= in_pos_z;
                sx_r  <= '0;
                sy_r  <= '0;
                sz_r  <= '0;
                k_r   <= '0;
                m_r   <= MS_XX;
                sph_r <= (count_r == '0);
                st_r  <= S_ISSUE;
              end
              OP_NOP: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_ISSUE: begin
          if (sph_r && m_r == MS_DD) begin
            t_r <= (ACC_W'(1) << 32) - t_r;
            m_r <= MS_PX;
          end else begin
            st_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mul_done) begin
            st_r <= S_ISSUE;
            unique case (m_r)
              MS_XX: begin t_r <= prod; m_r <= MS_YY; end
              MS_YY: begin t_r <= t_r + prod; m_r <= MS_ZZ; end
              MS_ZZ: begin t_r <= t_r + prod; m_r <= MS_DD; end
              MS_DD: begin t_r <= prod - t_r; m_r <= MS_PX; end
              MS_PX: begin sx_r <= sx_r + prod; m_r <= MS_PY; end
              MS_PY: begin sy_r <= sy_r + prod; m_r <= MS_PZ; end
              default: begin
                sz_r <= sz_r + prod;
                m_r  <= MS_XX;
                if (sph_r) begin
                  st_r <= S_FIN;
                end else begin
                  k_r <= k_r + CW'(1);
                  if (CW'(k_r + CW'(1)) < count_r) st_r <= S_ISSUE;
                  else if (CW'(k_r + CW'(1)) < CW'(SLOTS)) st_r <= S_ROT;
                  else sph_r <= 1'b1;
                end
              end
            endcase
          end
        end
        S_ROT: begin
          k_r <= k_r + CW'(1);
          if (CW'(k_r + CW'(1)) == CW'(SLOTS)) begin
            sph_r <= 1'b1;
            m_r   <= MS_XX;
            st_r  <= S_ISSUE;
          end
        end
        S_FIN: begin
          tx_r         <= fin_axis(px_r, sx_r);
          ty_r         <= fin_axis(py_r, sy_r);
          tz_r         <= fin_axis(pz_r, sz_r);
          out_status_r <= ST_OK;
          out_valid_r  <= 1'b1;
          sph_r        <= 1'b0;
          st_r         <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy         = (st_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_target_x = tx_r;
  assign out_target_y = ty_r;
  assign out_target_z = tz_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS)) else $error("agent count beyond table");
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FIN |=> out_valid && !busy) else $error("step finished without result");
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_operation == OP_STEP) |=> busy && !out_valid)
    else $error("step transfer did not start work");
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROT |-> (k_r >= count_r && count_r != '0 && !sph_r))
    else $error("rotation outside agent walk");
endmodule
`default_nettype wire
